### rtl/core/dpbp_pkg.sv
// shared types and constants for the depth pixel back-projection unit
package dpbp_pkg;

    localparam int PIXEL_INDEX_BITS_DEF = 12;
    localparam int PIX_FIELD_BITS       = 12;
    localparam int PIX_EXT_BITS         = 16;
    localparam int DATA_BITS            = 32;
    localparam int COEF_BITS            = 32;
    localparam int ACC_BITS             = 66;
    localparam int MAG_BITS             = 65;
    localparam int REM_BITS             = 66;
    localparam int Q_BITS               = 32;
    localparam int DIV_STEPS            = Q_BITS;
    localparam int FRAC_BITS            = 16;
    localparam int NUM_REGS             = 8;
    localparam int CFG_IDX_BITS         = 4;
    localparam int CFG_SEL_BITS         = $clog2(NUM_REGS);
    localparam int CFG_DATA_BITS        = 64;

    localparam logic [DATA_BITS-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_BITS-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [CFG_DATA_BITS-1:0] CFG_RESET [NUM_REGS] = '{
        64'd16777216, 64'd0,
        64'd72057594037927936, 64'd0,
        64'd0, 64'd16777216,
        64'd0, 64'd72057594037927936
    };

    typedef struct packed {
        logic [PIX_FIELD_BITS-1:0]   pixel_col;
        logic [PIX_FIELD_BITS-1:0]   pixel_row;
        logic signed [DATA_BITS-1:0] depth_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] point_x;
        logic signed [DATA_BITS-1:0] point_y;
        logic signed [DATA_BITS-1:0] point_z;
        logic                        divide_fault;
    } t_out_item;

    typedef struct packed {
        logic       fault;
        logic [2:0] neg;
        logic [2:0] ovf;
    } t_side;

    typedef logic [15:0][COEF_BITS-1:0] t_coef_mat;
    typedef logic [3:0][ACC_BITS-1:0]   t_acc_vec;
    typedef logic [2:0][REM_BITS-1:0]   t_rem_vec;
    typedef logic [2:0][Q_BITS-1:0]     t_q_vec;

endpackage

### rtl/core/dpbp_mac.sv
// matrix times homogeneous vector, three register stages
module dpbp_mac import dpbp_pkg::*; #(
    parameter int PIXEL_INDEX_BITS = PIXEL_INDEX_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_ce,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  t_coef_mat i_coef,
    output logic      o_valid,
    output t_acc_vec  o_acc
);

    localparam logic [PIX_EXT_BITS-1:0] PIX_MASK =
        PIX_EXT_BITS'((1 << PIXEL_INDEX_BITS) - 1);

    logic [PIX_EXT_BITS-1:0] col_ext;
    logic [PIX_EXT_BITS-1:0] row_ext;

    logic signed [COEF_BITS+PIX_EXT_BITS:0] r_pc [4];
    logic signed [COEF_BITS+PIX_EXT_BITS:0] r_pr [4];
    logic signed [COEF_BITS+DATA_BITS-1:0]  r_pd [4];
    logic signed [COEF_BITS-1:0]            r_pk [4];
    logic signed [ACC_BITS-1:0]             r_s0 [4];
    logic signed [ACC_BITS-1:0]             r_s1 [4];
    logic signed [ACC_BITS-1:0]             r_acc [4];
    logic [2:0]                             r_vld;

    assign col_ext = PIX_EXT_BITS'(i_item.pixel_col) & PIX_MASK;
    assign row_ext = PIX_EXT_BITS'(i_item.pixel_row) & PIX_MASK;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 4; i++) begin
                r_pc[i] <= $signed(i_coef[i*4])   * $signed({1'b0, col_ext});
                r_pr[i] <= $signed(i_coef[i*4+1]) * $signed({1'b0, row_ext});
                r_pd[i] <= $signed(i_coef[i*4+2]) * i_item.depth_value;
                r_pk[i] <= $signed(i_coef[i*4+3]);
                r_s0[i] <= (ACC_BITS'(r_pc[i]) <<< FRAC_BITS)
                         + (ACC_BITS'(r_pr[i]) <<< FRAC_BITS);
                r_s1[i] <= ACC_BITS'(r_pd[i]) + (ACC_BITS'(r_pk[i]) <<< FRAC_BITS);
                r_acc[i] <= r_s0[i] + r_s1[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_acc[i] = r_acc[i];
        end
    end

    assign o_valid = r_vld[2];

endmodule

### rtl/core/dpbp_dstep.sv
// one restoring division step for the three coordinate lanes
module dpbp_dstep import dpbp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  t_rem_vec            i_rem,
    input  t_q_vec              i_rq,
    input  logic [MAG_BITS-1:0] i_w,
    input  t_side               i_side,
    output logic                o_valid,
    output t_rem_vec            o_rem,
    output t_q_vec              o_rq,
    output logic [MAG_BITS-1:0] o_w,
    output t_side               o_side
);

    logic [REM_BITS-1:0] sh_val [3];
    logic [2:0]          ge;
    t_rem_vec            n_rem;
    t_q_vec              n_rq;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sh_val[k] = {i_rem[k][MAG_BITS-1:0], i_rq[k][Q_BITS-1]};
            ge[k]     = sh_val[k] >= REM_BITS'(i_w);
            n_rem[k]  = ge[k] ? sh_val[k] - REM_BITS'(i_w) : sh_val[k];
            n_rq[k]   = {i_rq[k][Q_BITS-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_rem  <= n_rem;
            o_rq   <= n_rq;
            o_w    <= i_w;
            o_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ce) begin
            o_valid <= i_valid;
        end
    end

endmodule

### rtl/core/dpbp_div.sv
// magnitude, overflow check and pipelined division by the w component
module dpbp_div import dpbp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_ce,
    input  logic     i_valid,
    input  t_acc_vec i_acc,
    output logic     o_valid,
    output t_q_vec   o_q,
    output t_side    o_side
);

    logic [3:0]          sgn;
    logic [ACC_BITS-1:0] abs_val [4];

    logic [MAG_BITS-1:0] r_m [3];
    logic [MAG_BITS-1:0] r_wa;
    t_side               r_side_a;
    logic                r_va;

    t_rem_vec            r_rem_b;
    t_q_vec              r_rq_b;
    logic [MAG_BITS-1:0] r_wb;
    t_side               r_side_b;
    logic                r_vb;

    wire                      w_vld  [DIV_STEPS+1];
    wire t_rem_vec            w_rem  [DIV_STEPS+1];
    wire t_q_vec              w_rq   [DIV_STEPS+1];
    wire [MAG_BITS-1:0]       w_w    [DIV_STEPS+1];
    wire t_side               w_side [DIV_STEPS+1];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sgn[k]     = i_acc[k][ACC_BITS-1];
            abs_val[k] = sgn[k] ? (ACC_BITS'(0) - i_acc[k]) : i_acc[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_m[k]          <= abs_val[k][MAG_BITS-1:0];
                r_side_a.neg[k] <= sgn[k] ^ sgn[3] ^ (k == 1);
            end
            r_wa           <= abs_val[3][MAG_BITS-1:0];
            r_side_a.fault <= (i_acc[3] == '0);
            r_side_a.ovf   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_side_b.ovf[k] <= MAG_BITS'(r_m[k][MAG_BITS-1:FRAC_BITS]) >= r_wa;
                r_rem_b[k]      <= REM_BITS'(r_m[k][MAG_BITS-1:FRAC_BITS]);
                r_rq_b[k]       <= {r_m[k][FRAC_BITS-1:0], {(Q_BITS-FRAC_BITS){1'b0}}};
            end
            r_side_b.fault <= r_side_a.fault;
            r_side_b.neg   <= r_side_a.neg;
            r_wb           <= r_wa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_ce) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    assign w_vld[0]  = r_vb;
    assign w_rem[0]  = r_rem_b;
    assign w_rq[0]   = r_rq_b;
    assign w_w[0]    = r_wb;
    assign w_side[0] = r_side_b;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        dpbp_dstep u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (i_ce),
            .i_valid (w_vld[s]),
            .i_rem   (w_rem[s]),
            .i_rq    (w_rq[s]),
            .i_w     (w_w[s]),
            .i_side  (w_side[s]),
            .o_valid (w_vld[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_rq    (w_rq[s+1]),
            .o_w     (w_w[s+1]),
            .o_side  (w_side[s+1])
        );
    end

    assign o_valid = w_vld[DIV_STEPS];
    assign o_q     = w_rq[DIV_STEPS];
    assign o_side  = w_side[DIV_STEPS];

endmodule

### rtl/core/depth_pixel_back_projection_unit.sv
// pipeline: 38 register stages (3 mac, 2 prep, 32 divide, 1 output)
// throughput: one item per cycle while the output is not stalled, a restoring divider stage per quotient bit
// a stall at the output holds the whole pipeline in place
// reset: synchronous active low, clears valid bits and loads the identity matrix
// the configuration port is always ready
module depth_pixel_back_projection_unit import dpbp_pkg::*; #(
    parameter int PIXEL_INDEX_BITS = PIXEL_INDEX_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_item                 i_item,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_item                o_item,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [CFG_DATA_BITS-1:0] r_cfg [NUM_REGS];
    t_coef_mat                coef;
    logic                     ce;
    logic                     mac_valid;
    t_acc_vec                 mac_acc;
    logic                     div_valid;
    t_q_vec                   div_q;
    t_side                    div_side;
    t_out_item                n_item;
    t_out_item                r_item;
    logic                     r_valid;

    function automatic logic [DATA_BITS-1:0] sat_out(
        input logic [Q_BITS-1:0] q,
        input logic              ovf,
        input logic              neg
    );
        logic [DATA_BITS-1:0] res;
        if (!neg) begin
            res = (ovf || q[Q_BITS-1]) ? SAT_MAX : q;
        end else begin
            res = (ovf || q[Q_BITS-1]) ? SAT_MIN : (DATA_BITS'(0) - q);
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                r_cfg[r] <= CFG_RESET[r];
            end
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index < CFG_IDX_BITS'(NUM_REGS)) begin
            r_cfg[i_cfg_index[CFG_SEL_BITS-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                coef[i*4+j] = r_cfg[i*2 + j/2][COEF_BITS*(j%2) +: COEF_BITS];
            end
        end
    end

    assign ce      = !(r_valid && i_stall);
    assign o_stall = !ce;

    dpbp_mac #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_coef  (coef),
        .o_valid (mac_valid),
        .o_acc   (mac_acc)
    );

    dpbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (mac_valid),
        .i_acc   (mac_acc),
        .o_valid (div_valid),
        .o_q     (div_q),
        .o_side  (div_side)
    );

    always_comb begin
        if (div_side.fault) begin
            n_item.point_x = '0;
            n_item.point_y = '0;
            n_item.point_z = '0;
        end else begin
            n_item.point_x = sat_out(div_q[0], div_side.ovf[0], div_side.neg[0]);
            n_item.point_y = sat_out(div_q[1], div_side.ovf[1], div_side.neg[1]);
            n_item.point_z = sat_out(div_q[2], div_side.ovf[2], div_side.neg[2]);
        end
        n_item.divide_fault = div_side.fault;
    end

    always_ff @(posedge i_clk) begin
        if (ce && div_valid) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ce) begin
            r_valid <= div_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/dpbp_checker.sv
// port-level checks for the back-projection unit and their bind
module dpbp_checker import dpbp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // a faulted point carries zero coordinates
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.divide_fault |->
            o_item.point_x == '0 && o_item.point_y == '0 && o_item.point_z == '0)
        else $error("fault with nonzero point");

    // input is held back only while the output is blocked
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without output stall");

    // a blocked result stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

endmodule

bind depth_pixel_back_projection_unit dpbp_checker u_dpbp_checker (.*);
